// ----- hw/rtl/swc_pkg.sv -----
`default_nettype none

package swc_pkg;

    // Field widths of the item and result channels.
    localparam int OP_W    = 2;
    localparam int SYM_W   = 5;
    localparam int COUNT_W = 7;

    // The match count saturates at the top of its field.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    // Operation codes of an input item.
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_TEXT  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Default table sizes.
    localparam int MAX_WORDS_DEF    = 64;
    localparam int MAX_WORD_LEN_DEF = 64;

    // Entries of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // A classified command as it travels from front to back.
    typedef struct packed {
        logic             load;
        logic             text;
        logic             clear;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_cmd;

endpackage

`default_nettype wire

// ----- hw/rtl/swc_item_if.sv -----
`default_nettype none

interface swc_item_if;
    import swc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, output operation, output symbol, output last,
                    input ready);
    modport sink   (input valid, input operation, input symbol, input last,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/swc_result_if.sv -----
`default_nettype none

interface swc_result_if;
    import swc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] match_count;
    logic               overflow;

    modport source (output valid, output match_count, output overflow,
                    input ready);
    modport sink   (input valid, input match_count, input overflow,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/swc_front.sv -----
`default_nettype none

module swc_front (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    swc_item_if.sink     i_item,
    output swc_pkg::t_cmd o_cmd,
    output logic         o_cmd_valid,
    input  wire logic    i_cmd_ready
);
    import swc_pkg::*;

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_q_data [QUEUE_DEPTH];
    logic [QP_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QP_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QC_W-1:0]   r_count, n_count;

    t_cmd cls_cmd;
    logic cls_keep;
    logic accept;
    logic push;
    logic pop;

    // Decode the operation; the unused code is taken and dropped.
    always_comb begin
        cls_cmd.load   = 1'b0;
        cls_cmd.text   = 1'b0;
        cls_cmd.clear  = 1'b0;
        cls_cmd.symbol = i_item.symbol;
        cls_cmd.last   = i_item.last;
        cls_keep       = 1'b1;
        unique case (i_item.operation)
            OP_LOAD:  cls_cmd.load  = 1'b1;
            OP_TEXT:  cls_cmd.text  = 1'b1;
            OP_CLEAR: cls_cmd.clear = 1'b1;
            default:  cls_keep      = 1'b0;
        endcase
    end

    assign i_item.ready = (r_count != QC_W'(QUEUE_DEPTH));
    assign accept       = i_item.valid && i_item.ready;
    assign push         = accept && cls_keep;
    assign o_cmd_valid  = (r_count != '0);
    assign o_cmd        = r_q_data[r_rd_ptr];
    assign pop          = o_cmd_valid && i_cmd_ready;

    // Queue pointers and fill count.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QP_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QP_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + QC_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_data[r_wr_ptr] <= cls_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/swc_back.sv -----
`default_nettype none

module swc_back #(
    parameter int MAX_WORDS    = swc_pkg::MAX_WORDS_DEF,
    parameter int MAX_WORD_LEN = swc_pkg::MAX_WORD_LEN_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire swc_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    swc_result_if.source       o_result
);
    import swc_pkg::*;

    localparam int SW_W = $clog2(MAX_WORDS + 1);
    localparam int WI_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int LW   = $clog2(MAX_WORD_LEN + 1);
    localparam int LS_DEPTH = MAX_WORDS * MAX_WORD_LEN;
    localparam int LA_W = (LS_DEPTH > 1) ? $clog2(LS_DEPTH) : 1;
    localparam int BA_W = $clog2(LS_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    // Memories.
    logic [SYM_W-1:0] letter_mem [LS_DEPTH];
    logic [LW-1:0]    len_mem    [MAX_WORDS];
    logic [LW-1:0]    pos_mem    [MAX_WORDS];

    // Control state.
    logic [1:0]           r_state;
    logic [SW_W-1:0]      r_stored;
    logic [LW-1:0]        r_open;
    logic [BA_W-1:0]      r_base;
    logic [COUNT_W-1:0]   r_finished;
    logic                 r_dropped;
    logic [MAX_WORDS-1:0] r_pos_vld;
    logic [SW_W-1:0]      r_widx;
    logic [BA_W-1:0]      r_walk_base;
    logic [SYM_W-1:0]     r_sym;
    logic                 r_text_last;
    logic                 r_s1_vld;
    logic                 r_s2_vld;
    logic                 r_out_vld;

    // Pipeline payload.
    logic [LW-1:0]        r_pos_rd;
    logic [LW-1:0]        r_len_rd;
    logic [WI_W-1:0]      r_s1_w;
    logic [BA_W-1:0]      r_s1_base;
    logic [WI_W-1:0]      r_s2_w;
    logic [LW-1:0]        r_s2_pos;
    logic [LW-1:0]        r_s2_len;
    logic                 r_s2_act;
    logic [SYM_W-1:0]     r_let_rd;
    logic [COUNT_W-1:0]   r_out_count;
    logic                 r_out_ovf;

    logic              out_free;
    logic              take;
    logic              table_full;
    logic              let_we;
    logic [LA_W-1:0]   let_wr_addr;
    logic [LW-1:0]     open_inc;
    logic              close_we;
    logic              issue;
    logic              walk_end;
    logic              drained;
    logic              emit;
    logic [LW-1:0]     s1_pos;
    logic              s1_act;
    logic [BA_W-1:0]   s1_sum;
    logic [LA_W-1:0]   s1_addr;
    logic              s2_hit;
    logic [LW-1:0]     s2_next;
    logic              s2_done;

    assign out_free = !r_out_vld || o_result.ready;

    // A closing text letter is taken only when the result slot will be free.
    assign o_cmd_ready = (r_state == S_IDLE)
                      && (!i_cmd.text || !i_cmd.last || out_free);
    assign take        = i_cmd_valid && o_cmd_ready;

    // Load path: append a letter and close the word on the last flag.
    assign table_full  = (r_stored >= SW_W'(MAX_WORDS));
    assign let_we      = take && i_cmd.load && !table_full
                      && (r_open < LW'(MAX_WORD_LEN));
    assign let_wr_addr = LA_W'(r_base + BA_W'(r_open));
    assign open_inc    = let_we ? r_open + LW'(1) : r_open;
    assign close_we    = take && i_cmd.load && !table_full && i_cmd.last;

    // Walk sequencing: one stored word issued per cycle.
    assign issue    = (r_state == S_WALK);
    assign walk_end = issue && ((r_widx + SW_W'(1)) == r_stored);
    assign drained  = (r_state == S_DRAIN) && !r_s1_vld && !r_s2_vld;
    assign emit     = drained && r_text_last;

    // Stage one: resolve the progress pointer and address the next letter.
    assign s1_pos  = r_pos_vld[r_s1_w] ? r_pos_rd : '0;
    assign s1_act  = (s1_pos < r_len_rd);
    assign s1_sum  = r_s1_base + BA_W'(s1_pos);
    assign s1_addr = s1_act ? LA_W'(s1_sum) : LA_W'(r_s1_base);

    // Stage two: compare and advance.
    assign s2_hit  = r_s2_vld && r_s2_act && (r_let_rd == r_sym);
    assign s2_next = r_s2_pos + LW'(1);
    assign s2_done = (s2_next == r_s2_len);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stored    <= '0;
            r_open      <= '0;
            r_base      <= '0;
            r_finished  <= '0;
            r_dropped   <= 1'b0;
            r_pos_vld   <= '0;
            r_widx      <= '0;
            r_walk_base <= '0;
            r_text_last <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;

            unique case (r_state)
                S_IDLE: begin
                    if (take && i_cmd.load) begin
                        if (table_full || (r_open >= LW'(MAX_WORD_LEN))) begin
                            r_dropped <= 1'b1;
                        end
                        if (i_cmd.last) begin
                            r_open <= '0;
                        end else begin
                            r_open <= open_inc;
                        end
                        if (close_we) begin
                            r_pos_vld[r_stored[WI_W-1:0]] <= 1'b0;
                            r_stored <= r_stored + SW_W'(1);
                            r_base   <= r_base + BA_W'(MAX_WORD_LEN);
                        end
                    end else if (take && i_cmd.text) begin
                        r_text_last <= i_cmd.last;
                        r_widx      <= '0;
                        r_walk_base <= '0;
                        r_state     <= (r_stored == '0) ? S_DRAIN : S_WALK;
                    end else if (take && i_cmd.clear) begin
                        r_stored   <= '0;
                        r_open     <= '0;
                        r_base     <= '0;
                        r_finished <= '0;
                        r_dropped  <= 1'b0;
                        r_pos_vld  <= '0;
                    end
                end
                S_WALK: begin
                    r_widx      <= r_widx + SW_W'(1);
                    r_walk_base <= r_walk_base + BA_W'(MAX_WORD_LEN);
                    if (walk_end) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (drained) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // A word that matches advances and may finish.
            if (s2_hit) begin
                r_pos_vld[r_s2_w] <= 1'b1;
                if (s2_done && (r_finished < COUNT_MAX)) begin
                    r_finished <= r_finished + COUNT_W'(1);
                end
            end

            // End of text: rewind every word for the next text.
            if (emit) begin
                r_pos_vld  <= '0;
                r_finished <= '0;
            end

            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (take && i_cmd.text) begin
            r_sym <= i_cmd.symbol;
        end
        r_s1_w    <= r_widx[WI_W-1:0];
        r_s1_base <= r_walk_base;
        r_s2_w    <= r_s1_w;
        r_s2_pos  <= s1_pos;
        r_s2_len  <= r_len_rd;
        r_s2_act  <= s1_act;
        if (emit) begin
            r_out_count <= r_finished;
            r_out_ovf   <= r_dropped;
        end
    end

    // Letter store: written by loads, read by the walk.
    always_ff @(posedge i_clk) begin
        if (let_we) begin
            letter_mem[let_wr_addr] <= i_cmd.symbol;
        end
        r_let_rd <= letter_mem[s1_addr];
    end

    // Word length table: written when a word closes.
    always_ff @(posedge i_clk) begin
        if (close_we) begin
            len_mem[r_stored[WI_W-1:0]] <= open_inc;
        end
        r_len_rd <= len_mem[r_widx[WI_W-1:0]];
    end

    // Progress pointers: valid bits stand for the zero after a rewind.
    always_ff @(posedge i_clk) begin
        if (s2_hit) begin
            pos_mem[r_s2_w] <= s2_next;
        end
        r_pos_rd <= pos_mem[r_widx[WI_W-1:0]];
    end

    assign o_result.valid       = r_out_vld;
    assign o_result.match_count = r_out_count;
    assign o_result.overflow    = r_out_ovf;

    // The walk pipeline is empty whenever a new command may start.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_s1_vld && !r_s2_vld))
        else $error("walk pipeline busy while idle");

    // No more words can finish than are stored.
    a_finished_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_finished <= r_stored))
        else $error("finished count exceeds stored words");

    // The open word never grows past the word length limit.
    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_open <= LW'(MAX_WORD_LEN)))
        else $error("open word longer than limit");

    // A result is only produced into a free slot.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_vld || o_result.ready))
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

// ----- hw/rtl/subsequence_word_counter.sv -----
// Subsequence word counter.
// Items arrive on i_item (operation, symbol, last) with a valid/ready
// transfer. Load items append a letter to the word being built and last
// closes it into the table; a clear item empties the table; text letters
// advance every stored word whose next letter matches.
// A text letter with last set produces one result on o_result: the number
// of stored words found as subsequences, and the overflow flag for dropped
// words or letters. Other items produce no result.
// A front stage classifies items into a two-entry command queue, so input
// transfers continue while the back part works. An item reaches the back
// part in the cycle after its transfer when the queue is empty.
// Load and clear leave the back part idle for the next command. A text
// letter walks the progress pointers of all stored words through one
// memory port, one word a cycle, through a three-stage read pipeline;
// the back part takes no new command until the walk has drained.
// A closing text letter shows its result once its walk has drained.
// The result waits in an output register while the receiver stalls; a
// closing text letter is not started until that register is free.
// Reset is synchronous and empties the table, the counters and the queue;
// no clearing pass is needed.
`default_nettype none

module subsequence_word_counter #(
    parameter int MAX_WORDS    = swc_pkg::MAX_WORDS_DEF,
    parameter int MAX_WORD_LEN = swc_pkg::MAX_WORD_LEN_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    swc_item_if.sink     i_item,
    swc_result_if.source o_result
);
    import swc_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_ready;

    // Front part: accept and classify items into the command queue.
    swc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready)
    );

    // Back part: table updates, the text walk and the result register.
    swc_back #(
        .MAX_WORDS    (MAX_WORDS),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire
